>>> rtl/core/tef_pkg.sv
// tef_pkg: shared types and codes of the timestamped event fifo
// request codes, slot entry layout and the counter update request
// no dependencies
package tef_pkg;

  localparam int unsigned IdW    = 8;
  localparam int unsigned DataW  = 32;
  localparam int unsigned ReqW   = 2;

  typedef enum logic [ReqW-1:0] {
    REQ_ENQUEUE = 2'd0,
    REQ_DEQUEUE = 2'd1,
    REQ_QUERY   = 2'd2
  } req_e;

  typedef struct packed {
    logic [IdW-1:0]   id;
    logic [DataW-1:0] aux;
    logic [DataW-1:0] stamp;
  } slot_entry_t;

  typedef struct packed {
    logic           inc;
    logic [IdW-1:0] id;
  } cnt_upd_t;

endpackage

>>> rtl/core/tef_if.sv
// tef_req_if and tef_rsp_if: valid/ready channels of the event fifo
// payload widths come from tef_pkg, pending count width from QUEUE_DEPTH
// depends on tef_pkg
interface tef_req_if;
  logic                        valid;
  logic                        ready;
  logic [tef_pkg::ReqW-1:0]    req_type;
  logic [tef_pkg::IdW-1:0]     event_id;
  logic [tef_pkg::DataW-1:0]   aux_data;
  logic [tef_pkg::DataW-1:0]   now_us;

  modport source (output valid, req_type, event_id, aux_data, now_us, input ready);
  modport sink   (input valid, req_type, event_id, aux_data, now_us, output ready);
endinterface

interface tef_rsp_if #(
  parameter int unsigned QUEUE_DEPTH = 64
);
  localparam int unsigned PendW = $clog2(QUEUE_DEPTH + 1);

  logic                        valid;
  logic                        ready;
  logic                        accepted;
  logic [tef_pkg::IdW-1:0]     out_event_id;
  logic [tef_pkg::DataW-1:0]   out_aux_data;
  logic [tef_pkg::DataW-1:0]   out_stamp;
  logic [PendW-1:0]            pending_before;
  logic [tef_pkg::DataW-1:0]   type_count;
  logic                        overflow_locked;

  modport source (output valid, accepted, out_event_id, out_aux_data, out_stamp,
                  pending_before, type_count, overflow_locked, input ready);
  modport sink   (input valid, accepted, out_event_id, out_aux_data, out_stamp,
                  pending_before, type_count, overflow_locked, output ready);
endinterface

>>> rtl/core/tef_slot_ram.sv
// tef_slot_ram: slot storage of the event queue, one write and one read port
// read data is registered and held while no read is requested
// depends on tef_pkg
module tef_slot_ram #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                         clk_i,
  input  logic                         we_i,
  input  logic [$clog2(DEPTH)-1:0]     waddr_i,
  input  tef_pkg::slot_entry_t         wdata_i,
  input  logic                         re_i,
  input  logic [$clog2(DEPTH)-1:0]     raddr_i,
  output tef_pkg::slot_entry_t         rdata_o
);

  tef_pkg::slot_entry_t mem_q [DEPTH];
  tef_pkg::slot_entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/tef_type_counters.sv
// tef_type_counters: per-type event counters, entry 0 is the total
// one increment request and one lookup per cycle, out of range reads give zero
// depends on tef_pkg
module tef_type_counters #(
  parameter int unsigned TYPE_COUNT = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  tef_pkg::cnt_upd_t           upd_i,
  input  logic [tef_pkg::IdW-1:0]     rd_id_i,
  output logic [tef_pkg::DataW-1:0]   rd_count_o
);

  localparam int unsigned TidW = $clog2(TYPE_COUNT);
  localparam logic [tef_pkg::IdW:0] IdLimit = (tef_pkg::IdW + 1)'(TYPE_COUNT);

  logic [tef_pkg::DataW-1:0] cnt_q [TYPE_COUNT];
  logic [TidW-1:0]           upd_idx;
  logic [TidW-1:0]           rd_idx;
  logic                      rd_in_range;

  assign upd_idx     = upd_i.id[TidW-1:0];
  assign rd_idx      = rd_id_i[TidW-1:0];
  assign rd_in_range = {1'b0, rd_id_i} < IdLimit;

  // caller only increments for ids 1 .. TYPE_COUNT-1, so the two writes never collide
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < int'(TYPE_COUNT); i++) begin
        cnt_q[i] <= '0;
      end
    end else if (upd_i.inc) begin
      cnt_q[upd_idx] <= cnt_q[upd_idx] + 1'b1;
      cnt_q[0]       <= cnt_q[0] + 1'b1;
    end
  end

  assign rd_count_o = rd_in_range ? cnt_q[rd_idx] : '0;

endmodule

>>> rtl/core/timestamped_event_fifo.sv
// timestamped_event_fifo: circular queue of timestamped events with type counters
// holds queue pointers, pending count, overflow lock and the result register
// depends on tef_pkg, tef_if, tef_slot_ram, tef_type_counters
//
//  channel  | dir | handshake     | payload
//  req_i    | in  | valid / ready | req_type, event_id, aux_data, now_us
//  rsp_o    | out | valid / ready | accepted, out_event_id, out_aux_data, out_stamp,
//           |     |               | pending_before, type_count, overflow_locked
//
// one request per cycle; its result shows on rsp_o in the cycle after the transfer
// the dequeued entry fields come from the registered read of the slot ram
// req_i is ready whenever the result register is empty or being taken in the same cycle
// a stalled rsp_o holds its result and stops further requests
// reset clears pointers, pending count, lock and all counters at once; slots keep no reset
module timestamped_event_fifo #(
  parameter int unsigned QUEUE_DEPTH = 64,
  parameter int unsigned TYPE_COUNT  = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  tef_req_if.sink    req_i,
  tef_rsp_if.source  rsp_o
);

  localparam int unsigned PtrW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(QUEUE_DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(QUEUE_DEPTH);
  localparam logic [tef_pkg::IdW:0] IdLimit = (tef_pkg::IdW + 1)'(TYPE_COUNT);

  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] pend_q, pend_d;
  logic            lock_q, lock_d;

  logic                      rsp_valid_q, rsp_valid_d;
  logic                      acc_q, acc_d;
  logic                      deq_q, deq_d;
  logic [CntW-1:0]           pend_out_q, pend_out_d;
  logic [tef_pkg::DataW-1:0] count_q, count_d;

  logic                      in_xfer;
  logic                      id_ok;
  logic                      full;
  logic                      enq_ok;
  logic                      deq_ok;
  tef_pkg::req_e             req;
  tef_pkg::slot_entry_t      wr_entry;
  tef_pkg::slot_entry_t      rd_entry;
  tef_pkg::cnt_upd_t         cnt_upd;
  logic [tef_pkg::DataW-1:0] rd_count;

  assign req_i.ready = !rsp_valid_q || rsp_o.ready;
  assign in_xfer     = req_i.valid && req_i.ready;
  assign req         = tef_pkg::req_e'(req_i.req_type);

  assign id_ok = (req_i.event_id != '0) && ({1'b0, req_i.event_id} < IdLimit);
  assign full  = pend_q == FullCnt;

  always_comb begin
    enq_ok      = 1'b0;
    deq_ok      = 1'b0;
    lock_d      = lock_q;
    pend_out_d  = '0;
    count_d     = '0;
    if (in_xfer) begin
      unique case (req)
        tef_pkg::REQ_ENQUEUE: begin
          if (!lock_q && id_ok) begin
            if (full) begin
              lock_d = 1'b1;
            end else begin
              enq_ok = 1'b1;
            end
          end
        end
        tef_pkg::REQ_DEQUEUE: begin
          pend_out_d = pend_q;
          deq_ok     = !lock_q && (pend_q != '0);
        end
        tef_pkg::REQ_QUERY: begin
          count_d = rd_count;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    pend_d   = pend_q;
    if (enq_ok) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      pend_d   = pend_q + 1'b1;
    end
    if (deq_ok) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      pend_d   = pend_q - 1'b1;
    end
  end

  assign acc_d       = enq_ok || deq_ok;
  assign deq_d       = deq_ok;
  assign rsp_valid_d = in_xfer || (rsp_valid_q && !rsp_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q    <= '0;
      rd_ptr_q    <= '0;
      pend_q      <= '0;
      lock_q      <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      wr_ptr_q    <= wr_ptr_d;
      rd_ptr_q    <= rd_ptr_d;
      pend_q      <= pend_d;
      lock_q      <= lock_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      acc_q      <= acc_d;
      deq_q      <= deq_d;
      pend_out_q <= pend_out_d;
      count_q    <= count_d;
    end
  end

  assign wr_entry.id    = req_i.event_id;
  assign wr_entry.aux   = req_i.aux_data;
  assign wr_entry.stamp = req_i.now_us;

  tef_slot_ram #(
    .DEPTH (QUEUE_DEPTH)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (enq_ok),
    .waddr_i (wr_ptr_q),
    .wdata_i (wr_entry),
    .re_i    (deq_ok),
    .raddr_i (rd_ptr_q),
    .rdata_o (rd_entry)
  );

  assign cnt_upd.inc = enq_ok;
  assign cnt_upd.id  = req_i.event_id;

  tef_type_counters #(
    .TYPE_COUNT (TYPE_COUNT)
  ) u_type_counters (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .upd_i      (cnt_upd),
    .rd_id_i    (req_i.event_id),
    .rd_count_o (rd_count)
  );

  // entry fields read as zero unless the transfer was a successful dequeue
  assign rsp_o.valid           = rsp_valid_q;
  assign rsp_o.accepted        = acc_q;
  assign rsp_o.out_event_id    = deq_q ? rd_entry.id    : '0;
  assign rsp_o.out_aux_data    = deq_q ? rd_entry.aux   : '0;
  assign rsp_o.out_stamp       = deq_q ? rd_entry.stamp : '0;
  assign rsp_o.pending_before  = pend_out_q;
  assign rsp_o.type_count      = count_q;
  assign rsp_o.overflow_locked = lock_q;

endmodule

>>> rtl/core/tef_checker.sv
// tef_checker: port level checks of the timestamped event fifo result channel
// bound to every timestamped_event_fifo instance
// depends on tef_pkg
module tef_checker #(
  parameter int unsigned PEND_W = 7
) (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        rsp_valid_i,
  input logic                        rsp_ready_i,
  input logic                        accepted_i,
  input logic [tef_pkg::IdW-1:0]     out_event_id_i,
  input logic [tef_pkg::DataW-1:0]   out_aux_data_i,
  input logic [tef_pkg::DataW-1:0]   out_stamp_i,
  input logic [PEND_W-1:0]           pending_before_i,
  input logic [tef_pkg::DataW-1:0]   type_count_i,
  input logic                        overflow_locked_i
);

  logic rsp_xfer;
  logic seen_lock_q;

  assign rsp_xfer = rsp_valid_i && rsp_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_lock_q <= 1'b0;
    end else if (rsp_xfer && overflow_locked_i) begin
      seen_lock_q <= 1'b1;
    end
  end

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i)
    else $error("result dropped while stalled");

  a_rsp_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> $stable(accepted_i) && $stable(out_event_id_i)
      && $stable(out_aux_data_i) && $stable(out_stamp_i) && $stable(pending_before_i)
      && $stable(type_count_i) && $stable(overflow_locked_i))
    else $error("stalled result changed");

  a_lock_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_xfer && seen_lock_q |-> overflow_locked_i)
    else $error("overflow lock cleared without reset");

  a_lock_rejects: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_xfer && seen_lock_q |-> !accepted_i)
    else $error("request accepted while locked");

  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_xfer && !accepted_i |-> out_event_id_i == '0 && out_aux_data_i == '0
      && out_stamp_i == '0)
    else $error("entry fields set on a rejected request");

endmodule

bind timestamped_event_fifo tef_checker #(
  .PEND_W ($clog2(QUEUE_DEPTH + 1))
) u_tef_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .rsp_valid_i       (rsp_o.valid),
  .rsp_ready_i       (rsp_o.ready),
  .accepted_i        (rsp_o.accepted),
  .out_event_id_i    (rsp_o.out_event_id),
  .out_aux_data_i    (rsp_o.out_aux_data),
  .out_stamp_i       (rsp_o.out_stamp),
  .pending_before_i  (rsp_o.pending_before),
  .type_count_i      (rsp_o.type_count),
  .overflow_locked_i (rsp_o.overflow_locked)
);
